>>> hw/rtl/nggf_pkg.sv
// Package for the GGA fix field parser: word types, line state, character codes.
// Used by nggf_field_scan and nmea_gga_fix_field_parser_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nggf_pkg;

  localparam int MAX_LINE_DEF = 128;

  localparam int ACC_W  = 28;
  localparam int WIDE_W = 36;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [3:0] FLD_QUALITY  = 4'd6;
  localparam logic [3:0] FLD_SATS     = 4'd7;
  localparam logic [3:0] FLD_HDOP     = 4'd8;
  localparam logic [3:0] FLD_ALTITUDE = 4'd9;
  localparam logic [3:0] FLD_DGPS_AGE = 4'd13;
  localparam logic [3:0] FLD_MAX      = 4'd15;

  localparam logic signed [WIDE_W-1:0] ACC_CAP   = WIDE_W'(100000000);
  localparam logic signed [ACC_W-1:0]  OUT_LIMIT = ACC_W'(99999999);

  localparam logic signed [ACC_W-1:0] HDOP_EMPTY     = -ACC_W'(1000);
  localparam logic signed [ACC_W-1:0] ALTITUDE_EMPTY = -ACC_W'(9999000);
  localparam logic signed [ACC_W-1:0] DGPS_AGE_EMPTY = -ACC_W'(1000);

  // Quality tracks 0..256; 256 stands for anything above 255.
  localparam logic [8:0] QUAL_SAT = 9'd256;

  typedef enum logic [2:0] {
    PH_LEAD = 3'd0,
    PH_SIGN = 3'd1,
    PH_INT  = 3'd2,
    PH_FRAC = 3'd3,
    PH_STOP = 3'd4
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       line_end;
  } char_word_t;

  typedef struct packed {
    logic [7:0]              fix_quality;
    logic [7:0]              sat_count;
    logic signed [ACC_W-1:0] hdop_milli;
    logic signed [ACC_W-1:0] altitude_milli;
    logic signed [ACC_W-1:0] dgps_age_milli;
  } fix_word_t;

  typedef struct packed {
    logic [3:0]              field_number;
    logic                    rejected;
    logic                    star_seen;
    logic [8:0]              quality;
    logic [7:0]              satellites;
    logic signed [ACC_W-1:0] hdop;
    logic signed [ACC_W-1:0] altitude;
    logic signed [ACC_W-1:0] dgps_age;
    scan_phase_t             phase;
    logic                    neg;
    logic [1:0]              frac_count;
    logic [3:0]              empty_marks;
  } line_state_t;

  localparam line_state_t LINE_RESET = '{
    field_number: 4'd0,
    rejected:     1'b0,
    star_seen:    1'b0,
    quality:      9'd0,
    satellites:   8'd0,
    hdop:         '0,
    altitude:     '0,
    dgps_age:     '0,
    phase:        PH_LEAD,
    neg:          1'b0,
    frac_count:   2'd0,
    empty_marks:  4'hF
  };

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    begin
      r = v;
      if (v > ACC_CAP) r = ACC_CAP;
      if (v < -ACC_CAP) r = -ACC_CAP;
      sat_acc = r[ACC_W-1:0];
    end
  endfunction

  function automatic logic signed [ACC_W-1:0] out_fixed(input logic signed [ACC_W-1:0] v,
                                                        input logic empty,
                                                        input logic signed [ACC_W-1:0] dflt);
    logic signed [ACC_W-1:0] r;
    begin
      r = empty ? dflt : v;
      if (r > OUT_LIMIT) r = OUT_LIMIT;
      if (r < -OUT_LIMIT) r = -OUT_LIMIT;
      out_fixed = r;
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/nggf_field_scan.sv
// Next-state logic for one character: length/reject tracking, comma split,
// number scanner and per-field accumulators, plus the result word. Uses nggf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nggf_field_scan import nggf_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF,
  parameter int CW       = $clog2(MAX_LINE + 1)
) (
  input  line_state_t     state,
  input  logic [CW-1:0]   char_count,
  input  char_word_t      word,
  output line_state_t     state_next,
  output logic [CW-1:0]   char_count_next,
  output logic            fire,
  output fix_word_t       result
);

  logic [7:0]               c;
  logic [3:0]               fld;
  logic                     rej;
  logic                     parse;
  logic                     fixed;
  logic                     active;
  logic                     blank;
  logic                     digit;
  logic [3:0]               d;
  logic                     early_phase;
  logic signed [ACC_W-1:0]  sel_acc;
  logic signed [WIDE_W-1:0] sel_wide;
  logic signed [WIDE_W-1:0] int_add;
  logic signed [WIDE_W-1:0] frac_add;
  logic signed [ACC_W-1:0]  int_val;
  logic signed [ACC_W-1:0]  frac_val;
  logic [12:0]              qual_wide;
  logic [8:0]               qual_val;
  logic [7:0]               sats_val;
  logic [3:0]               d_frac_w;
  logic                     acc_we;
  logic signed [ACC_W-1:0]  acc_wdata;

  assign c   = word.char_byte;
  assign fld = state.field_number;

  assign char_count_next = (char_count < CW'(MAX_LINE)) ? char_count + CW'(1) : char_count;

  assign rej = state.rejected
             | ((char_count == '0) && (c != CH_DOLLAR))
             | ((c == CH_NUL) && (char_count < CW'(6)));

  assign parse = !rej && !state.star_seen && (char_count < CW'(MAX_LINE - 1));

  assign fixed  = (fld == FLD_HDOP) || (fld == FLD_ALTITUDE) || (fld == FLD_DGPS_AGE);
  assign active = (fld == FLD_QUALITY) || (fld == FLD_SATS) || fixed;
  assign blank  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign d      = digit ? 4'(c - CH_ZERO) : 4'd0;
  assign early_phase = (state.phase == PH_LEAD) || (state.phase == PH_SIGN)
                    || (state.phase == PH_INT);

  always_comb begin
    case (fld)
      FLD_HDOP:     sel_acc = state.hdop;
      FLD_ALTITUDE: sel_acc = state.altitude;
      default:      sel_acc = state.dgps_age;
    endcase
  end

  assign sel_wide = WIDE_W'(sel_acc);

  // Integer digit: acc*10 +- d*1000; fraction digit: acc +- d*weight.
  always_comb begin
    case (state.frac_count)
      2'd0:    frac_add = WIDE_W'(d) * WIDE_W'(100);
      2'd1:    frac_add = WIDE_W'(d) * WIDE_W'(10);
      default: frac_add = WIDE_W'(d);
    endcase
  end

  assign d_frac_w = d;
  assign int_add  = WIDE_W'(d_frac_w) * WIDE_W'(1000);
  assign int_val  = sat_acc((sel_wide <<< 3) + (sel_wide <<< 1)
                            + (state.neg ? -int_add : int_add));
  assign frac_val = sat_acc(sel_wide + (state.neg ? -frac_add : frac_add));

  // Negative quality never rises above zero, so hold it at zero.
  assign qual_wide = {4'd0, state.quality} * 13'd10 + 13'(d);
  assign qual_val  = state.neg ? state.quality
                   : ((qual_wide >= 13'(QUAL_SAT)) ? QUAL_SAT : qual_wide[8:0]);
  assign sats_val  = state.neg ? (state.satellites * 8'd10 - 8'(d))
                               : (state.satellites * 8'd10 + 8'(d));

  always_comb begin
    state_next = state;
    state_next.rejected = rej;
    acc_we    = 1'b0;
    acc_wdata = int_val;
    if (parse) begin
      if ((c == CH_NUL) || (c == CH_STAR)) begin
        state_next.star_seen = 1'b1;
      end else if (c == CH_COMMA) begin
        if (fld != FLD_MAX) state_next.field_number = fld + 4'd1;
        state_next.phase      = PH_LEAD;
        state_next.neg        = 1'b0;
        state_next.frac_count = 2'd0;
      end else begin
        if (fld == FLD_SATS)     state_next.empty_marks[0] = 1'b0;
        if (fld == FLD_HDOP)     state_next.empty_marks[1] = 1'b0;
        if (fld == FLD_ALTITUDE) state_next.empty_marks[2] = 1'b0;
        if (fld == FLD_DGPS_AGE) state_next.empty_marks[3] = 1'b0;
        if (active) begin
          if ((state.phase == PH_LEAD) && blank) begin
            state_next.phase = PH_LEAD;
          end else if ((state.phase == PH_LEAD) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
            state_next.phase = PH_SIGN;
            state_next.neg   = (c == CH_MINUS);
          end else if (early_phase && digit) begin
            state_next.phase = PH_INT;
            if (fld == FLD_SATS) begin
              state_next.satellites = sats_val;
            end else if (fld == FLD_QUALITY) begin
              state_next.quality = qual_val;
            end else begin
              acc_we    = 1'b1;
              acc_wdata = int_val;
            end
          end else if (early_phase && fixed && (c == CH_DOT)) begin
            state_next.phase = PH_FRAC;
          end else if ((state.phase == PH_FRAC) && digit && (state.frac_count != 2'd3)) begin
            acc_we    = 1'b1;
            acc_wdata = frac_val;
            state_next.frac_count = state.frac_count + 2'd1;
          end else begin
            state_next.phase = PH_STOP;
          end
        end
      end
    end
    if (acc_we) begin
      case (fld)
        FLD_HDOP:     state_next.hdop     = acc_wdata;
        FLD_ALTITUDE: state_next.altitude = acc_wdata;
        default:      state_next.dgps_age = acc_wdata;
      endcase
    end
  end

  assign fire = word.line_end && !rej && (char_count_next >= CW'(6))
             && (state_next.field_number >= FLD_QUALITY);

  assign result.fix_quality     = (state_next.quality >= QUAL_SAT) ? 8'd255
                                                                   : state_next.quality[7:0];
  assign result.sat_count       = state_next.satellites;
  assign result.hdop_milli      = out_fixed(state_next.hdop, state_next.empty_marks[1],
                                            HDOP_EMPTY);
  assign result.altitude_milli  = out_fixed(state_next.altitude, state_next.empty_marks[2],
                                            ALTITUDE_EMPTY);
  assign result.dgps_age_milli  = out_fixed(state_next.dgps_age, state_next.empty_marks[3],
                                            DGPS_AGE_EMPTY);

endmodule

`default_nettype wire

>>> hw/rtl/nmea_gga_fix_field_parser_unit.sv
// GGA fix field parser: one character word per cycle in unless stalled, at most one fix
// word per line out. fix_valid rises once a line's last character word has left the input
// register and its fix word is in the result register. The line state updates in one
// pass of nggf_field_scan between the input register and the result register.
// Only a line end that meets a full, unaccepted result register stalls input.
// Reset (rst, synchronous): empties both registers and clears the line state.
`timescale 1ns / 1ps
`default_nettype none

module nmea_gga_fix_field_parser_unit import nggf_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  char_word_t char_word,
  output logic       fix_valid,
  input  logic       fix_ready,
  output fix_word_t  fix_word
);

  localparam int CW = $clog2(MAX_LINE + 1);

  logic          in_full;
  char_word_t    in_word;
  line_state_t   state;
  line_state_t   state_next;
  logic [CW-1:0] char_count;
  logic [CW-1:0] char_count_next;
  logic          fire;
  fix_word_t     result;
  logic          advance;

  // A line end may need the result register; other characters never do.
  assign advance    = in_full && (!in_word.line_end || !fix_valid || fix_ready);
  assign char_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (char_ready) begin
      in_full <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      in_word <= char_word;
    end
  end

  nggf_field_scan #(
    .MAX_LINE (MAX_LINE),
    .CW       (CW)
  ) u_scan (
    .state           (state),
    .char_count      (char_count),
    .word            (in_word),
    .state_next      (state_next),
    .char_count_next (char_count_next),
    .fire            (fire),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= LINE_RESET;
      char_count <= '0;
    end else if (advance) begin
      if (in_word.line_end) begin
        state      <= LINE_RESET;
        char_count <= '0;
      end else begin
        state      <= state_next;
        char_count <= char_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid <= 1'b0;
    end else if (advance && fire) begin
      fix_valid <= 1'b1;
    end else if (fix_ready) begin
      fix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      fix_word <= result;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking bench for nmea_gga_fix_field_parser_unit: GGA sentences go in one character
// word at a time and each fix word coming out is compared with a local field-by-field parser.
// Depends on nggf_pkg and the parser RTL only.
`timescale 1ns / 1ps

module testbench import nggf_pkg::*; ();

  localparam int     LINE_CAP  = MAX_LINE_DEF;
  localparam longint ACC_SPAN  = 100000000;
  localparam longint OUT_SPAN  = 99999999;
  localparam int     CHAR_GOAL = 1700;

  logic       clk;
  logic       rst        = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_ready;
  char_word_t char_word  = '0;
  logic       fix_valid;
  logic       fix_ready  = 1'b0;
  fix_word_t  fix_word;

  nmea_gga_fix_field_parser_unit #(.MAX_LINE(LINE_CAP)) uut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_word  (char_word),
    .fix_valid  (fix_valid),
    .fix_ready  (fix_ready),
    .fix_word   (fix_word)
  );

  fix_word_t   fix_expected[$];
  logic [7:0]  line_buf[$];
  int          fails      = 0;
  int          chars_sent = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int          rx_hold_req = 0;

  // Line state of the local parser
  int          ln_count;
  logic [3:0]  ln_field;
  bit          ln_rej;
  bit          ln_star;
  longint      qual_acc;
  logic [31:0] sats_acc;
  longint      milli_acc[3];
  scan_phase_t ph;
  bit          ph_neg;
  int          frac_n;
  logic [3:0]  empty_m;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void clear_gga_line();
    ln_count  = 0;
    ln_field  = '0;
    ln_rej    = 1'b0;
    ln_star   = 1'b0;
    qual_acc  = 0;
    sats_acc  = '0;
    milli_acc = '{0, 0, 0};
    ph        = PH_LEAD;
    ph_neg    = 1'b0;
    frac_n    = 0;
    empty_m   = 4'hF;
  endfunction

  function automatic longint cap_acc(input longint v);
    if (v > ACC_SPAN) return ACC_SPAN;
    if (v < -ACC_SPAN) return -ACC_SPAN;
    return v;
  endfunction

  function automatic int milli_slot(input logic [3:0] f);
    if (f == FLD_HDOP) return 0;
    if (f == FLD_ALTITUDE) return 1;
    return 2;
  endfunction

  function automatic logic signed [ACC_W-1:0] milli_word(input longint v, input bit empty,
                                                          input longint dflt);
    longint r;
    r = empty ? dflt : v;
    if (r > OUT_SPAN) r = OUT_SPAN;
    if (r < -OUT_SPAN) r = -OUT_SPAN;
    return r[ACC_W-1:0];
  endfunction

  // Number scanner for the current field: blanks, sign, digits, then '.' and up to
  // three decimals on the fixed-point fields; anything else freezes the value.
  function automatic void scan_number_char(input logic [7:0] c);
    bit     is_fixed;
    bit     digit;
    int     d;
    int     s;
    longint w;
    is_fixed = (ln_field == FLD_HDOP || ln_field == FLD_ALTITUDE || ln_field == FLD_DGPS_AGE);
    digit    = (c >= CH_ZERO && c <= CH_NINE);
    d        = digit ? int'(c) - int'(CH_ZERO) : 0;
    s        = milli_slot(ln_field);
    if (!(ln_field == FLD_QUALITY || ln_field == FLD_SATS || is_fixed)) return;
    if (ph == PH_LEAD && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
      return;
    end else if (ph == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
      ph     = PH_SIGN;
      ph_neg = (c == CH_MINUS);
    end else if (ph <= PH_INT && digit) begin
      if (ln_field == FLD_SATS)
        sats_acc = sats_acc * 32'd10 + (ph_neg ? -32'(d) : 32'(d));
      else if (ln_field == FLD_QUALITY)
        qual_acc = cap_acc(qual_acc * 10 + (ph_neg ? -d : d));
      else
        milli_acc[s] = cap_acc(milli_acc[s] * 10 + (ph_neg ? -d * 1000 : d * 1000));
      ph = PH_INT;
    end else if (ph <= PH_INT && is_fixed && c == CH_DOT) begin
      ph = PH_FRAC;
    end else if (ph == PH_FRAC && digit && frac_n < 3) begin
      w = (frac_n == 0) ? 100 : (frac_n == 1) ? 10 : 1;
      milli_acc[s] = cap_acc(milli_acc[s] + (ph_neg ? -d * w : d * w));
      frac_n++;
    end else begin
      ph = PH_STOP;
    end
  endfunction

  // Advance the line state by one accepted character; queue a fix word at line end.
  function automatic void gga_track_char(input logic [7:0] c, input bit last);
    int        idx;
    fix_word_t fw;
    idx = ln_count;
    if (ln_count < LINE_CAP) ln_count++;
    if (idx == 0 && c != CH_DOLLAR) ln_rej = 1'b1;
    if (c == CH_NUL && idx < 6) ln_rej = 1'b1;
    if (!ln_rej && !ln_star && idx < LINE_CAP - 1) begin
      if (c == CH_NUL || c == CH_STAR) begin
        ln_star = 1'b1;
      end else if (c == CH_COMMA) begin
        if (ln_field < FLD_MAX) ln_field++;
        ph     = PH_LEAD;
        ph_neg = 1'b0;
        frac_n = 0;
      end else begin
        case (ln_field)
          FLD_SATS:     empty_m[0] = 1'b0;
          FLD_HDOP:     empty_m[1] = 1'b0;
          FLD_ALTITUDE: empty_m[2] = 1'b0;
          FLD_DGPS_AGE: empty_m[3] = 1'b0;
          default: ;
        endcase
        scan_number_char(c);
      end
    end
    if (last) begin
      if (!ln_rej && ln_count >= 6 && ln_field >= FLD_QUALITY) begin
        fw.fix_quality     = (qual_acc < 0) ? 8'd0 : (qual_acc > 255) ? 8'd255 : qual_acc[7:0];
        fw.sat_count       = sats_acc[7:0];
        fw.hdop_milli      = milli_word(milli_acc[0], empty_m[1], longint'(HDOP_EMPTY));
        fw.altitude_milli  = milli_word(milli_acc[1], empty_m[2], longint'(ALTITUDE_EMPTY));
        fw.dgps_age_milli  = milli_word(milli_acc[2], empty_m[3], longint'(DGPS_AGE_EMPTY));
        fix_expected.push_back(fw);
      end
      clear_gga_line();
    end
  endfunction

  // Result side: random stalls, plus long hold-offs requested by the stimulus
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        stall       = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall == 0 && rx_idle_on && $urandom_range(0, 99) < 6) begin
        stall = $urandom_range(1, 18);
      end
      if (stall > 0) begin
        fix_ready <= 1'b0;
        stall--;
      end else begin
        fix_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    fix_word_t want;
    if (!rst && fix_valid && fix_ready) begin
      if (fix_expected.size() == 0) begin
        $error("fix word %h arrived with none expected", fix_word);
        fails++;
      end else begin
        want = fix_expected.pop_front();
        if (fix_word.fix_quality !== want.fix_quality) begin
          $error("fix_quality expected %0d got %0d", want.fix_quality, fix_word.fix_quality);
          fails++;
        end
        if (fix_word.sat_count !== want.sat_count) begin
          $error("sat_count expected %0d got %0d", want.sat_count,
                 fix_word.sat_count);
          fails++;
        end
        if (fix_word.hdop_milli !== want.hdop_milli) begin
          $error("hdop_milli expected %0d got %0d", want.hdop_milli, fix_word.hdop_milli);
          fails++;
        end
        if (fix_word.altitude_milli !== want.altitude_milli) begin
          $error("altitude_milli expected %0d got %0d", want.altitude_milli,
                 fix_word.altitude_milli);
          fails++;
        end
        if (fix_word.dgps_age_milli !== want.dgps_age_milli) begin
          $error("dgps_age_milli expected %0d got %0d", want.dgps_age_milli,
                 fix_word.dgps_age_milli);
          fails++;
        end
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input bit last);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 99) < 7) ? $urandom_range(1, 18) : 0;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= '{char_byte: c, line_end: last};
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    gga_track_char(c, last);
    chars_sent++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // Drop valid and hold until every queued fix word has come back
  task automatic wait_for_fixes();
    int guard;
    guard = 0;
    char_valid <= 1'b0;
    @(posedge clk);
    while (fix_expected.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic put_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_number(input bit is_fixed);
    string junk;
    int    b;
    junk = " .+-Mx";
    if ($urandom_range(0, 99) < 12) return;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 2)) begin
        b = $urandom_range(0, 5);
        line_buf.push_back((b == 5) ? CH_SPACE : CH_TAB + 8'(b));
      end
    end
    case ($urandom_range(0, 9))
      0, 1:    line_buf.push_back(CH_MINUS);
      2:       line_buf.push_back(CH_PLUS);
      default: ;
    endcase
    put_digits(($urandom_range(0, 99) < 6) ? $urandom_range(7, 11) : $urandom_range(0, 3));
    if (is_fixed && $urandom_range(0, 99) < 70) begin
      line_buf.push_back(CH_DOT);
      put_digits($urandom_range(0, 5));
    end
    if ($urandom_range(0, 99) < 8) line_buf.push_back(junk[$urandom_range(0, 5)]);
  endtask

  // Well-formed GGA sentence with random field content; compact drops the text of
  // fields 1..5, pad stretches field 1 so the numbers land near the line cap.
  task automatic build_gga(input bit compact, input bit pad);
    string hex;
    int    f;
    int    stop_at;
    hex     = "0123456789ABCDEF";
    stop_at = ($urandom_range(0, 99) < 8) ? $urandom_range(1, 14) : 14;
    put_str(compact ? "$" : "$GPGGA");
    for (f = 1; f <= stop_at; f++) begin
      line_buf.push_back(CH_COMMA);
      case (f)
        1: begin
          if (!compact) put_str("123519");
          if (pad) repeat ($urandom_range(60, 110)) line_buf.push_back(8'($urandom_range(65, 90)));
        end
        2:  if (!compact) put_str("4807.038");
        3:  if (!compact) put_str("N");
        4:  if (!compact) put_str("01131.000");
        5:  if (!compact) put_str("E");
        6, 7: put_number(1'b0);
        10, 12: put_str("M");
        14: put_digits($urandom_range(0, 4));
        default: put_number(1'b1);
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        line_buf.push_back(CH_STAR);
        line_buf.push_back(hex[$urandom_range(0, 15)]);
        line_buf.push_back(hex[$urandom_range(0, 15)]);
        put_str("\r\n");
      end
      6: line_buf.push_back(CH_STAR);
      7: begin
        line_buf.push_back(CH_NUL);
        put_str(",9,9");
      end
      8: put_str("\r\n");
      default: ;
    endcase
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(1, 40);
    line_buf.push_back($urandom_range(0, 1) ? CH_DOLLAR : 8'($urandom_range(0, 255)));
    repeat (n - 1)
      line_buf.push_back(($urandom_range(0, 99) < 30) ? CH_COMMA : 8'($urandom_range(0, 255)));
  endtask

  // Broken sentence: a stray byte, a bad first character or an early NUL
  task automatic mangle_line();
    int top;
    top = (line_buf.size() > 6) ? 5 : line_buf.size() - 1;
    case ($urandom_range(0, 2))
      0: line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      1: line_buf[0] = 8'($urandom_range(0, 255));
      default: line_buf[$urandom_range(1, top)] = CH_NUL;
    endcase
  endtask

  task automatic test_directed_fields();
    // high quality clamps, -1 satellites wraps, extra decimals truncate, star ends data
    put_str("$,,,,,,300,-1,1.2345,-.5,,,,*9");
    send_line();
    // negative quality, blank-only and junk fields read zero, age set
    put_str("$,,,,,,-2, ,x,,,,,7.0");
    send_line();
    // NUL inside the first six characters makes the line too short
    put_str("$,,,");
    line_buf.push_back(CH_NUL);
    put_str(",,,1");
    send_line();
    put_str("G,,,,,,1");
    send_line();
    // wide values saturate, while 256 satellites wraps to zero
    put_str("$,,,,,,99999999999,256,999999999.9,-123456789,,,,0.0015");
    send_line();
    wait_for_fixes();
  endtask

  task automatic test_random_sentences();
    int kind;
    while (chars_sent < CHAR_GOAL - 1100) begin
      tx_idle_on = ($urandom_range(0, 4) != 0);
      rx_idle_on = ($urandom_range(0, 4) != 0);
      kind       = $urandom_range(0, 99);
      if (kind < 65) begin
        build_gga($urandom_range(0, 1), 1'b0);
      end else if (kind < 80) begin
        build_gga($urandom_range(0, 1), 1'b0);
        mangle_line();
      end else if (kind < 90) begin
        build_noise();
      end else begin
        build_gga(1'b1, 1'b0);
      end
      send_line();
    end
    wait_for_fixes();
  endtask

  task automatic test_long_lines();
    repeat (3) begin
      build_gga($urandom_range(0, 1), 1'b1);
      send_line();
    end
    wait_for_fixes();
  endtask

  // Hold off the result side while compact lines keep coming, so the output
  // register fills and a line end has to stall
  task automatic test_input_stall();
    tx_idle_on  = 1'b0;
    rx_idle_on  = 1'b0;
    rx_hold_req = 400;
    repeat (14) begin
      build_gga(1'b1, 1'b0);
      send_line();
    end
    wait_for_fixes();
  endtask

  task automatic test_tail_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (chars_sent < CHAR_GOAL) begin
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_gga($urandom_range(0, 1), 1'b0);
      send_line();
    end
  endtask

  initial begin
    clear_gga_line();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_fields();
    test_random_sentences();
    test_long_lines();
    test_input_stall();
    test_tail_no_idle();
    wait_for_fixes();
    repeat (8) @(posedge clk);
    if (fix_expected.size() != 0) begin
      $error("%0d fix words never arrived", fix_expected.size());
      fails++;
    end
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/nggf_pkg.sv
hw/rtl/nggf_field_scan.sv
hw/rtl/nmea_gga_fix_field_parser_unit.sv
tb/sv/testbench.sv
